// ----- design/dsfd_pkg.sv -----
// shared types and constants of the dle/stx/etx frame decoder
package dsfd_pkg;

  // frame store size and derived counter width
  localparam int unsigned MAX_FRAME = 512;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int unsigned MIN_FRAME = 3;

  // framing bytes
  localparam logic [7:0] DLE_BYTE = 8'h10;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] ESC_BYTE = 8'h1B;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  // frame end status codes
  localparam logic [2:0] ST_GOOD_BUS    = 3'd0;
  localparam logic [2:0] ST_GOOD_DEVICE = 3'd1;
  localparam logic [2:0] ST_GOOD_OTHER  = 3'd2;
  localparam logic [2:0] ST_SHORT       = 3'd3;
  localparam logic [2:0] ST_BAD_SUM     = 3'd4;
  localparam logic [2:0] ST_OVERFLOW    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_FILE_MODE  = 2'd0;
  localparam logic [1:0] REG_BUS_CMD    = 2'd1;
  localparam logic [1:0] REG_DEVICE_CMD = 2'd2;

  // one result request
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [8:0] index;
    logic [2:0] status;
    logic [9:0] length;
    logic [7:0] command;
    logic [7:0] payload_len;
  } res_t;

endpackage

// ----- design/dle_stx_frame_decoder_checksum.sv -----
// top level of the dle/stx/etx byte-stuffed frame decoder with checksum check
//
// Takes one raw serial byte per request and removes DLE stuffing. Every kept
// byte leaves as a data result with its frame position; DLE-STX gives a
// restart, DLE followed by an unexpected byte an abort, and DLE-ETX a frame
// end with status, length, command and declared payload length. The leading
// byte of an escape pair and a byte dropped because the store is full give no
// result. The decode is one short step between the input handshake and a
// result register, so one byte is taken every cycle while the skid register is
// free; a two-entry output stage (result register plus skid register) lets the
// input keep flowing while a result waits, and input ready drops only while
// the skid register is occupied. Configuration sits on an APB port at byte
// addresses 0 (file_mode), 4 (bus_message_command) and 8 (device_message_command).
module dle_stx_frame_decoder_checksum
  import dsfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [8:0] out_index_o,
  output logic [2:0] frame_status_o,
  output logic [9:0] frame_length_o,
  output logic [7:0] frame_command_o,
  output logic [7:0] frame_payload_len_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_ESCAPE  = 2'd1;
  localparam logic [1:0] PH_MESSAGE = 2'd2;
  localparam logic [1:0] PH_UNUSED  = 2'd3;

  // configuration registers
  logic       file_mode_q;
  logic [7:0] bus_cmd_q;
  logic [7:0] dev_cmd_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_mode_q <= 1'b0;
      bus_cmd_q   <= 8'd147;
      dev_cmd_q   <= 8'd160;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FILE_MODE:  file_mode_q <= pwdata[0];
        REG_BUS_CMD:    bus_cmd_q   <= pwdata[7:0];
        REG_DEVICE_CMD: dev_cmd_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_FILE_MODE:  prdata = {31'd0, file_mode_q};
      REG_BUS_CMD:    prdata = {24'd0, bus_cmd_q};
      REG_DEVICE_CMD: prdata = {24'd0, dev_cmd_q};
      default:        prdata = 32'd0;
    endcase
  end

  // decoder state
  logic [1:0]       phase_q, phase_d;
  logic             latch_q, latch_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       first_q, first_d;
  logic [7:0]       second_q, second_d;
  logic             ovf_q, ovf_d;

  // output stage
  res_t res_d, out_q, skid_q;
  logic res_v;
  logic out_v_q, skid_v_q;
  logic in_acc, out_take;
  logic is_esc, do_keep, do_clear;
  logic [7:0] c;

  assign in_ready_o = !skid_v_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_take   = out_v_q && out_ready_i;
  assign c          = in_byte_i;
  assign is_esc     = (c == ESC_BYTE) && file_mode_q;

  // per-byte decode
  always_comb begin
    phase_d  = phase_q;
    latch_d  = latch_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    first_d  = first_q;
    second_d = second_q;
    ovf_d    = ovf_q;
    res_v    = 1'b0;
    res_d    = '0;
    do_keep  = 1'b0;
    do_clear = 1'b0;

    case (phase_q)
      PH_ESCAPE: begin
        if (c == ETX_BYTE) begin
          res_v        = 1'b1;
          res_d.kind   = KIND_END;
          res_d.length = 10'(cnt_q);
          res_d.command     = first_q;
          res_d.payload_len = second_q;
          if (cnt_q < CNT_W'(MIN_FRAME))   res_d.status = ST_SHORT;
          else if (ovf_q)                  res_d.status = ST_OVERFLOW;
          else if (sum_q != 8'd0)          res_d.status = ST_BAD_SUM;
          else if (first_q == bus_cmd_q)   res_d.status = ST_GOOD_BUS;
          else if (first_q == dev_cmd_q)   res_d.status = ST_GOOD_DEVICE;
          else                             res_d.status = ST_GOOD_OTHER;
          do_clear = 1'b1;
          phase_d  = PH_START;
        end else if (c == STX_BYTE) begin
          res_v      = 1'b1;
          res_d.kind = KIND_RESTART;
          do_clear   = 1'b1;
          phase_d    = PH_MESSAGE;
        end else if (c == DLE_BYTE || is_esc || latch_q) begin
          phase_d = PH_MESSAGE;
          do_keep = 1'b1;
        end else begin
          res_v      = 1'b1;
          res_d.kind = KIND_ABORT;
          do_clear   = 1'b1;
          phase_d    = PH_START;
        end
      end
      PH_MESSAGE: begin
        if (c == DLE_BYTE || (is_esc && !latch_q)) begin
          phase_d = PH_ESCAPE;
        end else begin
          do_keep = 1'b1;
        end
      end
      default: begin
        phase_d = (c == DLE_BYTE) ? PH_ESCAPE : PH_START;
        if (is_esc) latch_d = 1'b1;
      end
    endcase

    // frame clear after end, restart or abort
    if (do_clear) begin
      cnt_d    = '0;
      sum_d    = '0;
      first_d  = '0;
      second_d = '0;
      ovf_d    = 1'b0;
    end

    // keep one unstuffed byte, or mark overflow when the store is full
    if (do_keep) begin
      if (cnt_q >= CNT_W'(MAX_FRAME)) begin
        ovf_d = 1'b1;
      end else begin
        if (cnt_q == CNT_W'(0)) first_d = c;
        else if (cnt_q == CNT_W'(1)) second_d = c;
        sum_d       = sum_q + c;
        cnt_d       = cnt_q + CNT_W'(1);
        res_v       = 1'b1;
        res_d.kind  = KIND_DATA;
        res_d.data  = c;
        res_d.index = 9'(cnt_q);
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      latch_q  <= 1'b0;
      cnt_q    <= '0;
      sum_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      ovf_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      latch_q  <= latch_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      first_q  <= first_d;
      second_q <= second_d;
      ovf_q    <= ovf_d;
    end
  end

  // output stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) skid_v_q <= 1'b0;
    end else if (in_acc && res_v) begin
      if (out_v_q && !out_take) skid_v_q <= 1'b1;
      else                      out_v_q  <= 1'b1;
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) out_q <= skid_q;
    end else if (in_acc && res_v) begin
      if (out_v_q && !out_take) skid_q <= res_d;
      else                      out_q  <= res_d;
    end
  end

  assign out_valid_o         = out_v_q;
  assign out_kind_o          = out_q.kind;
  assign out_byte_o          = out_q.data;
  assign out_index_o         = out_q.index;
  assign frame_status_o      = out_q.status;
  assign frame_length_o      = out_q.length;
  assign frame_command_o     = out_q.command;
  assign frame_payload_len_o = out_q.payload_len;

  // checks on the output stage and the decoder state
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry without result entry");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_take) |=> (skid_v_q && $stable(skid_q)))
    else $error("waiting skid entry lost or changed");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(out_q)))
    else $error("stalled result changed");

  a_phase_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_UNUSED) else $error("unused phase code reached");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAME)) else $error("byte count past store size");

endmodule
